[design/icpnea_pkg.sv]
`default_nettype none

package icpnea_pkg;

	// Sizing of the point stream and of the moment sums.
	localparam int MAX_POINTS = 4096;
	localparam int COORD_BITS = 24;
	localparam int FIELD_W    = 24;
	localparam int PROD_W     = 2 * FIELD_W;
	localparam int SUM_W      = 62;
	localparam int N_SRC      = 10;
	localparam int N_CROSS    = 9;
	localparam int N_SUM      = N_SRC + N_CROSS;
	localparam int SUM_IDX_W  = $clog2(N_SUM);
	localparam int IDX_W      = 3;

	typedef logic signed [FIELD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [SUM_IDX_W-1:0]      sum_idx_t;
	typedef logic [IDX_W-1:0]          idx_t;

	// Coordinate range and accumulator saturation bound.
	localparam coord_t COORD_HI  = coord_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam coord_t COORD_LO  = coord_t'(-(64'sd1 <<< (COORD_BITS - 1)));
	localparam sum_t   SUM_BOUND = sum_t'(64'(MAX_POINTS) << (2 * COORD_BITS - 2));
	localparam idx_t   IDX_LAST  = idx_t'(5);

	// Slots of the source moment sums.
	localparam sum_idx_t S_WW = sum_idx_t'(0);
	localparam sum_idx_t S_XX = sum_idx_t'(1);
	localparam sum_idx_t S_YY = sum_idx_t'(2);
	localparam sum_idx_t S_ZZ = sum_idx_t'(3);
	localparam sum_idx_t S_YW = sum_idx_t'(4);
	localparam sum_idx_t S_ZW = sum_idx_t'(5);
	localparam sum_idx_t S_XW = sum_idx_t'(6);
	localparam sum_idx_t S_XZ = sum_idx_t'(7);
	localparam sum_idx_t S_YZ = sum_idx_t'(8);
	localparam sum_idx_t S_XY = sum_idx_t'(9);

	// Slots of the cross moment sums.
	localparam sum_idx_t C_DXW = sum_idx_t'(10);
	localparam sum_idx_t C_DYW = sum_idx_t'(11);
	localparam sum_idx_t C_DZW = sum_idx_t'(12);
	localparam sum_idx_t C_DXY = sum_idx_t'(13);
	localparam sum_idx_t C_DZY = sum_idx_t'(14);
	localparam sum_idx_t C_DXZ = sum_idx_t'(15);
	localparam sum_idx_t C_DYX = sum_idx_t'(16);
	localparam sum_idx_t C_DYZ = sum_idx_t'(17);
	localparam sum_idx_t C_DZX = sum_idx_t'(18);

	// How an emitted entry is formed from one or two sums.
	typedef enum logic [2:0] {
		OP_ZERO,
		OP_A,
		OP_NEG_A,
		OP_ADD,
		OP_SUB
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		sum_idx_t a;
		sum_idx_t b;
	} entry_op_t;

	// Clamp a 24-bit field to the signed COORD_BITS range.
	function automatic coord_t sat_coord(input coord_t v);
		coord_t r;
		r = v;
		if (v > COORD_HI) begin
			r = COORD_HI;
		end else if (v < COORD_LO) begin
			r = COORD_LO;
		end
		return r;
	endfunction

	// Add a product into an accumulator and clamp to the bound.
	function automatic sum_t sat_add(input sum_t acc, input prod_t p);
		sum_t r;
		r = acc + sum_t'(p);
		if (r > SUM_BOUND) begin
			r = SUM_BOUND;
		end else if (r < -SUM_BOUND) begin
			r = -SUM_BOUND;
		end
		return r;
	endfunction

	function automatic entry_op_t mk_op(input op_kind_t k, input sum_idx_t a, input sum_idx_t b);
		entry_op_t r;
		r.kind = k;
		r.a    = a;
		r.b    = b;
		return r;
	endfunction

	// Recipe of each matrix and vector entry; entries not listed are zero.
	function automatic entry_op_t entry_op(input logic vec, input idx_t row, input idx_t col);
		entry_op_t r;
		r = mk_op(OP_ZERO, S_WW, S_WW);
		if (vec) begin
			case (row)
				3'd0: r = mk_op(OP_SUB, C_DXW, S_XW);
				3'd1: r = mk_op(OP_SUB, C_DYW, S_YW);
				3'd2: r = mk_op(OP_SUB, C_DZW, S_ZW);
				3'd3: r = mk_op(OP_SUB, C_DXY, C_DYX);
				3'd4: r = mk_op(OP_SUB, C_DYZ, C_DZY);
				3'd5: r = mk_op(OP_SUB, C_DZX, C_DXZ);
				default: r = mk_op(OP_ZERO, S_WW, S_WW);
			endcase
		end else begin
			case ({row, col})
				{3'd0, 3'd0}: r = mk_op(OP_A,     S_WW, S_WW);
				{3'd0, 3'd3}: r = mk_op(OP_A,     S_YW, S_WW);
				{3'd0, 3'd5}: r = mk_op(OP_NEG_A, S_ZW, S_WW);
				{3'd1, 3'd1}: r = mk_op(OP_A,     S_WW, S_WW);
				{3'd1, 3'd3}: r = mk_op(OP_NEG_A, S_XW, S_WW);
				{3'd1, 3'd4}: r = mk_op(OP_A,     S_ZW, S_WW);
				{3'd2, 3'd2}: r = mk_op(OP_A,     S_WW, S_WW);
				{3'd2, 3'd4}: r = mk_op(OP_NEG_A, S_YW, S_WW);
				{3'd2, 3'd5}: r = mk_op(OP_A,     S_XW, S_WW);
				{3'd3, 3'd0}: r = mk_op(OP_A,     S_YW, S_WW);
				{3'd3, 3'd1}: r = mk_op(OP_NEG_A, S_XW, S_WW);
				{3'd3, 3'd3}: r = mk_op(OP_ADD,   S_XX, S_YY);
				{3'd3, 3'd4}: r = mk_op(OP_NEG_A, S_XZ, S_WW);
				{3'd3, 3'd5}: r = mk_op(OP_NEG_A, S_YZ, S_WW);
				{3'd4, 3'd1}: r = mk_op(OP_A,     S_ZW, S_WW);
				{3'd4, 3'd2}: r = mk_op(OP_NEG_A, S_YW, S_WW);
				{3'd4, 3'd3}: r = mk_op(OP_NEG_A, S_XZ, S_WW);
				{3'd4, 3'd4}: r = mk_op(OP_ADD,   S_YY, S_ZZ);
				{3'd4, 3'd5}: r = mk_op(OP_NEG_A, S_XY, S_WW);
				{3'd5, 3'd0}: r = mk_op(OP_NEG_A, S_ZW, S_WW);
				{3'd5, 3'd2}: r = mk_op(OP_A,     S_XW, S_WW);
				{3'd5, 3'd3}: r = mk_op(OP_NEG_A, S_YZ, S_WW);
				{3'd5, 3'd4}: r = mk_op(OP_NEG_A, S_XY, S_WW);
				{3'd5, 3'd5}: r = mk_op(OP_ADD,   S_XX, S_ZZ);
				default: r = mk_op(OP_ZERO, S_WW, S_WW);
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/icp_normal_equation_accumulator_unit.sv]
// ICP normal-equation accumulator.
// Pair channel (pair_valid / pair_stall): one matched point pair per
// transaction, source (x, y, z, w) and target (x, y, z) in signed Q8.16,
// with final_pair marking the last pair of a set.
// Entry channel (entry_valid / entry_stall): 42 transactions per set, the
// 6x6 system matrix in row-major order and then the 6-entry right-hand
// vector; end_of_run marks the last one.
// Throughput is one pair per cycle while pair_stall is low. A final pair
// passes an input register, a bank of 19 multipliers and their product
// register, and the saturating accumulators into the output bank, before
// the first entry of its set is loaded into the output register; the
// following entries come one per cycle while the receiver does not stall.
// A final pair copies the sums into an output bank and clears them, so the
// next set accumulates while the previous one drains. A second final pair
// that reaches the accumulators while the bank still drains raises
// pair_stall until the last entry of the bank is loaded into the output
// register. When entry_stall is high the output register holds its entry
// and the bank waits. Reset clears the accumulators and drops both valids.
`default_nettype none

module icp_normal_equation_accumulator_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            pair_valid,
	output logic                           pair_stall,
	input  wire  icpnea_pkg::coord_t       src_x,
	input  wire  icpnea_pkg::coord_t       src_y,
	input  wire  icpnea_pkg::coord_t       src_z,
	input  wire  icpnea_pkg::coord_t       src_w,
	input  wire  icpnea_pkg::coord_t       dst_x,
	input  wire  icpnea_pkg::coord_t       dst_y,
	input  wire  icpnea_pkg::coord_t       dst_z,
	input  wire                            final_pair,
	output logic                           entry_valid,
	input  wire                            entry_stall,
	output logic                           is_vector,
	output icpnea_pkg::idx_t               row,
	output icpnea_pkg::idx_t               col,
	output icpnea_pkg::sum_t               value,
	output logic                           end_of_run
);

	import icpnea_pkg::*;

	// Stage 1: registered input pair.
	logic   valid_s1;
	logic   final_s1;
	coord_t sx_s1, sy_s1, sz_s1, sw_s1, dx_s1, dy_s1, dz_s1;

	// Stage 2: registered products.
	logic   valid_s2;
	logic   final_s2;
	prod_t  prod_s2 [N_SUM];

	// Accumulators and output bank.
	sum_t   acc_q  [N_SUM];
	sum_t   bank_q [N_SUM];
	logic   bank_busy_q;

	// Emission counters and output register.
	logic   vec_q;
	idx_t   row_q;
	idx_t   col_q;
	logic   entry_valid_q;
	logic   is_vector_q;
	idx_t   row_out_q;
	idx_t   col_out_q;
	sum_t   value_q;
	logic   end_of_run_q;

	logic   advance;
	logic   snap;
	logic   load_entry;
	logic   last_entry;
	coord_t x, y, z, w, dx, dy, dz;
	prod_t  prod [N_SUM];
	sum_t   acc_next [N_SUM];
	entry_op_t eop;
	sum_t   opa, opb, lhs, rhs, entry_val;
	logic   do_sub;

	// The pipeline holds only when a final pair meets a bank that still drains.
	assign advance    = !(valid_s2 && final_s2 && bank_busy_q);
	assign pair_stall = !advance;
	assign snap       = valid_s2 && final_s2 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			final_s1 <= final_pair;
			sx_s1    <= src_x;
			sy_s1    <= src_y;
			sz_s1    <= src_z;
			sw_s1    <= src_w;
			dx_s1    <= dst_x;
			dy_s1    <= dst_y;
			dz_s1    <= dst_z;
		end
	end

	// Clamp the coordinates and form the 19 moment products.
	always_comb begin
		x  = sat_coord(sx_s1);
		y  = sat_coord(sy_s1);
		z  = sat_coord(sz_s1);
		w  = sat_coord(sw_s1);
		dx = sat_coord(dx_s1);
		dy = sat_coord(dy_s1);
		dz = sat_coord(dz_s1);
		prod[S_WW]  = prod_t'(w)  * prod_t'(w);
		prod[S_XX]  = prod_t'(x)  * prod_t'(x);
		prod[S_YY]  = prod_t'(y)  * prod_t'(y);
		prod[S_ZZ]  = prod_t'(z)  * prod_t'(z);
		prod[S_YW]  = prod_t'(y)  * prod_t'(w);
		prod[S_ZW]  = prod_t'(z)  * prod_t'(w);
		prod[S_XW]  = prod_t'(x)  * prod_t'(w);
		prod[S_XZ]  = prod_t'(x)  * prod_t'(z);
		prod[S_YZ]  = prod_t'(y)  * prod_t'(z);
		prod[S_XY]  = prod_t'(x)  * prod_t'(y);
		prod[C_DXW] = prod_t'(dx) * prod_t'(w);
		prod[C_DYW] = prod_t'(dy) * prod_t'(w);
		prod[C_DZW] = prod_t'(dz) * prod_t'(w);
		prod[C_DXY] = prod_t'(dx) * prod_t'(y);
		prod[C_DZY] = prod_t'(dz) * prod_t'(y);
		prod[C_DXZ] = prod_t'(dx) * prod_t'(z);
		prod[C_DYX] = prod_t'(dy) * prod_t'(x);
		prod[C_DYZ] = prod_t'(dy) * prod_t'(z);
		prod[C_DZX] = prod_t'(dz) * prod_t'(x);
	end

	// Product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			final_s2 <= final_s1;
			for (int i = 0; i < N_SUM; i++) begin
				prod_s2[i] <= prod[i];
			end
		end
	end

	// Saturating accumulation of each product lane.
	always_comb begin
		for (int i = 0; i < N_SUM; i++) begin
			acc_next[i] = sat_add(acc_q[i], prod_s2[i]);
		end
	end

	// A final pair hands its totals to the bank and restarts the sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_SUM; i++) begin
				acc_q[i] <= '0;
			end
		end else if (valid_s2 && advance) begin
			for (int i = 0; i < N_SUM; i++) begin
				acc_q[i] <= final_s2 ? '0 : acc_next[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap) begin
			for (int i = 0; i < N_SUM; i++) begin
				bank_q[i] <= acc_next[i];
			end
		end
	end

	// Form the current entry from one or two bank sums with one adder.
	always_comb begin
		eop    = entry_op(vec_q, row_q, col_q);
		opa    = bank_q[eop.a];
		opb    = bank_q[eop.b];
		lhs    = '0;
		rhs    = '0;
		do_sub = 1'b0;
		case (eop.kind)
			OP_A: begin
				lhs = opa;
			end
			OP_NEG_A: begin
				rhs    = opa;
				do_sub = 1'b1;
			end
			OP_ADD: begin
				lhs = opa;
				rhs = opb;
			end
			OP_SUB: begin
				lhs    = opa;
				rhs    = opb;
				do_sub = 1'b1;
			end
			default: begin
				lhs = '0;
			end
		endcase
		entry_val = lhs + (do_sub ? ~rhs : rhs) + sum_t'(do_sub);
	end

	assign load_entry = bank_busy_q && (!entry_valid_q || !entry_stall);
	assign last_entry = vec_q && (row_q == IDX_LAST);

	// Emission sequencer: walks the matrix and then the vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_busy_q <= 1'b0;
			vec_q       <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
		end else if (snap) begin
			bank_busy_q <= 1'b1;
			vec_q       <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
		end else if (load_entry) begin
			if (last_entry) begin
				bank_busy_q <= 1'b0;
			end else if (vec_q) begin
				row_q <= row_q + idx_t'(1);
			end else if (col_q == IDX_LAST) begin
				col_q <= '0;
				if (row_q == IDX_LAST) begin
					vec_q <= 1'b1;
					row_q <= '0;
				end else begin
					row_q <= row_q + idx_t'(1);
				end
			end else begin
				col_q <= col_q + idx_t'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else if (load_entry) begin
			entry_valid_q <= 1'b1;
		end else if (!entry_stall) begin
			entry_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_entry) begin
			is_vector_q  <= vec_q;
			row_out_q    <= row_q;
			col_out_q    <= col_q;
			value_q      <= entry_val;
			end_of_run_q <= last_entry;
		end
	end

	assign entry_valid = entry_valid_q;
	assign is_vector   = is_vector_q;
	assign row         = row_out_q;
	assign col         = col_out_q;
	assign value       = value_q;
	assign end_of_run  = end_of_run_q;

`ifndef SYNTHESIS
	// The input stalls only behind a final pair waiting for the bank.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (valid_s2 && final_s2 && bank_busy_q))
		else $error("pair_stall without a pending final pair");

	// A new emission run starts at the first matrix entry.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bank_busy_q) |-> (!vec_q && row_q == '0 && col_q == '0))
		else $error("emission run did not start at the first entry");

	// Vector entries always report column zero.
	a_vec_col: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_valid && is_vector) |-> (col == '0))
		else $error("vector entry with nonzero column");

	// The run ends only on the last vector entry.
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_valid && end_of_run) |-> (is_vector && row == IDX_LAST))
		else $error("end_of_run on a wrong entry");

	// Sums are cleared right after being handed to the bank.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		snap |=> (acc_q[S_WW] == '0 && acc_q[C_DXW] == '0))
		else $error("sums not cleared after a final pair");

	// The sum of squared w can never go negative.
	a_ww_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_q[S_WW][SUM_W-1])
		else $error("sum of w squared went negative");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import icpnea_pkg::*;

	// One matched point pair as it is offered on the pair channel.
	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
		coord_t dx;
		coord_t dy;
		coord_t dz;
		bit     last;
	} point_pair_t;

	// One entry of the linearized system as it leaves the block.
	typedef struct {
		bit   is_vec;
		idx_t row;
		idx_t col;
		sum_t value;
		bit   last;
	} system_entry_t;

	localparam coord_t ONE_Q = 24'sh010000;
	localparam int BIG_SET_PAIRS = 32;
	localparam int LONG_HOLD = 200;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   pair_valid  = 1'b0;
	logic   pair_stall;
	coord_t src_x       = '0;
	coord_t src_y       = '0;
	coord_t src_z       = '0;
	coord_t src_w       = '0;
	coord_t dst_x       = '0;
	coord_t dst_y       = '0;
	coord_t dst_z       = '0;
	logic   final_pair  = 1'b0;
	logic   entry_valid;
	logic   entry_stall = 1'b0;
	logic   is_vector;
	idx_t   row;
	idx_t   col;
	sum_t   value;
	logic   end_of_run;

	// Predicted moment sums, indexed by the package slot names.
	longint moment_sum[N_SUM];
	system_entry_t expected_entries[$];

	int mismatches    = 0;
	int pairs_sent    = 0;
	int sets_closed   = 0;
	int entries_seen  = 0;
	bit sender_gaps   = 1'b1;
	bit receiver_gaps = 1'b1;
	int rx_hold_left  = 0;
	int rx_burst_left = 0;

	icp_normal_equation_accumulator_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pair_valid  (pair_valid),
		.pair_stall  (pair_stall),
		.src_x       (src_x),
		.src_y       (src_y),
		.src_z       (src_z),
		.src_w       (src_w),
		.dst_x       (dst_x),
		.dst_y       (dst_y),
		.dst_z       (dst_z),
		.final_pair  (final_pair),
		.entry_valid (entry_valid),
		.entry_stall (entry_stall),
		.is_vector   (is_vector),
		.row         (row),
		.col         (col),
		.value       (value),
		.end_of_run  (end_of_run)
	);

	always #4 clk = ~clk;

	// Print one line per mismatch and count every one.
	task automatic note_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Clamp a sign-extended coordinate to the configured coordinate range.
	function automatic longint clamp_coord(input coord_t c);
		longint v;
		longint hi;
		longint lo;
		v = c;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -(longint'(1) <<< (COORD_BITS - 1));
		if (v > hi) begin
			v = hi;
		end else if (v < lo) begin
			v = lo;
		end
		return v;
	endfunction

	// Add a product into a moment sum, saturating at the point-count bound.
	function automatic longint clamp_sum(input longint acc, input longint p);
		longint bound;
		longint r;
		bound = longint'(MAX_POINTS) <<< (2 * COORD_BITS - 2);
		r = acc + p;
		if (r > bound) begin
			r = bound;
		end else if (r < -bound) begin
			r = -bound;
		end
		return r;
	endfunction

	// Accumulate one accepted pair; on the last pair of a set, queue the
	// 36 matrix entries and 6 vector entries and clear the sums.
	task automatic accumulate_pair(input point_pair_t p);
		longint x, y, z, w, dx, dy, dz;
		longint prod[N_SUM];
		longint m[6][6];
		longint b[6];
		system_entry_t e;
		x = clamp_coord(p.x);
		y = clamp_coord(p.y);
		z = clamp_coord(p.z);
		w = clamp_coord(p.w);
		dx = clamp_coord(p.dx);
		dy = clamp_coord(p.dy);
		dz = clamp_coord(p.dz);
		prod[S_WW] = w * w;
		prod[S_XX] = x * x;
		prod[S_YY] = y * y;
		prod[S_ZZ] = z * z;
		prod[S_YW] = y * w;
		prod[S_ZW] = z * w;
		prod[S_XW] = x * w;
		prod[S_XZ] = x * z;
		prod[S_YZ] = y * z;
		prod[S_XY] = x * y;
		prod[C_DXW] = dx * w;
		prod[C_DYW] = dy * w;
		prod[C_DZW] = dz * w;
		prod[C_DXY] = dx * y;
		prod[C_DZY] = dz * y;
		prod[C_DXZ] = dx * z;
		prod[C_DYX] = dy * x;
		prod[C_DYZ] = dy * z;
		prod[C_DZX] = dz * x;
		for (int k = 0; k < N_SUM; k++) begin
			moment_sum[k] = clamp_sum(moment_sum[k], prod[k]);
		end
		if (!p.last) begin
			return;
		end

		// Build the symmetric system matrix from the source sums.
		for (int i = 0; i < 6; i++) begin
			for (int j = 0; j < 6; j++) begin
				m[i][j] = 0;
			end
		end
		m[0][0] = moment_sum[S_WW];
		m[1][1] = moment_sum[S_WW];
		m[2][2] = moment_sum[S_WW];
		m[3][3] = moment_sum[S_XX] + moment_sum[S_YY];
		m[4][4] = moment_sum[S_YY] + moment_sum[S_ZZ];
		m[5][5] = moment_sum[S_XX] + moment_sum[S_ZZ];
		m[0][3] = moment_sum[S_YW];
		m[0][5] = -moment_sum[S_ZW];
		m[1][3] = -moment_sum[S_XW];
		m[1][4] = moment_sum[S_ZW];
		m[2][4] = -moment_sum[S_YW];
		m[2][5] = moment_sum[S_XW];
		m[3][4] = -moment_sum[S_XZ];
		m[3][5] = -moment_sum[S_YZ];
		m[4][5] = -moment_sum[S_XY];
		for (int i = 0; i < 6; i++) begin
			for (int j = i + 1; j < 6; j++) begin
				m[j][i] = m[i][j];
			end
		end

		// Right-hand side from the cross sums and the source sums.
		b[0] = moment_sum[C_DXW] - moment_sum[S_XW];
		b[1] = moment_sum[C_DYW] - moment_sum[S_YW];
		b[2] = moment_sum[C_DZW] - moment_sum[S_ZW];
		b[3] = moment_sum[C_DXY] - moment_sum[C_DYX];
		b[4] = moment_sum[C_DYZ] - moment_sum[C_DZY];
		b[5] = moment_sum[C_DZX] - moment_sum[C_DXZ];

		for (int i = 0; i < 6; i++) begin
			for (int j = 0; j < 6; j++) begin
				e.is_vec = 1'b0;
				e.row = idx_t'(i);
				e.col = idx_t'(j);
				e.value = sum_t'(m[i][j]);
				e.last = 1'b0;
				expected_entries.insert(expected_entries.size(), e);
			end
		end
		for (int i = 0; i < 6; i++) begin
			e.is_vec = 1'b1;
			e.row = idx_t'(i);
			e.col = '0;
			e.value = sum_t'(b[i]);
			e.last = (i == 5);
			expected_entries.insert(expected_entries.size(), e);
		end
		for (int k = 0; k < N_SUM; k++) begin
			moment_sum[k] = 0;
		end
		sets_closed++;
	endtask

	// Offer one pair until it is accepted, then maybe leave a gap.
	task automatic send_pair(input point_pair_t p);
		pair_valid <= 1'b1;
		src_x <= p.x;
		src_y <= p.y;
		src_z <= p.z;
		src_w <= p.w;
		dst_x <= p.dx;
		dst_y <= p.dy;
		dst_z <= p.dz;
		final_pair <= p.last;
		@(posedge clk);
		while (pair_stall) begin
			@(posedge clk);
		end
		accumulate_pair(p);
		pairs_sent++;
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			pair_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Stop offering pairs until every queued entry has come out.
	task automatic wait_for_entries();
		pair_valid <= 1'b0;
		while (expected_entries.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic point_pair_t make_pair(input coord_t x, input coord_t y,
			input coord_t z, input coord_t w, input coord_t dx, input coord_t dy,
			input coord_t dz, input bit last);
		point_pair_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.w = w;
		p.dx = dx;
		p.dy = dy;
		p.dz = dz;
		p.last = last;
		return p;
	endfunction

	// Mix of extremes, zero, full-range noise and small plausible coordinates.
	function automatic coord_t random_coord();
		coord_t c;
		case ($urandom_range(0, 9))
			0: c = COORD_HI;
			1: c = COORD_LO;
			2: c = '0;
			3, 4, 5: c = coord_t'($urandom());
			default: c = coord_t'($urandom_range(0, 32'h200000) - 32'h100000);
		endcase
		return c;
	endfunction

	function automatic point_pair_t random_pair(input bit last);
		coord_t w;
		w = ($urandom_range(0, 1) == 1) ? ONE_Q : random_coord();
		return make_pair(random_coord(), random_coord(), random_coord(), w,
			random_coord(), random_coord(), random_coord(), last);
	endfunction

	// Check each transaction on the entry channel and drive entry_stall.
	always @(posedge clk) begin
		if (arst_n && entry_valid && !entry_stall) begin
			entries_seen++;
			if (expected_entries.size() == 0) begin
				note_mismatch($sformatf("unexpected entry row %0d col %0d vec %0b",
					row, col, is_vector));
			end else begin
				system_entry_t e;
				e = expected_entries.pop_front();
				if (is_vector !== e.is_vec) begin
					note_mismatch($sformatf("is_vector got %0b want %0b", is_vector, e.is_vec));
				end
				if (row !== e.row) begin
					note_mismatch($sformatf("row got %0d want %0d", row, e.row));
				end
				if (col !== e.col) begin
					note_mismatch($sformatf("col got %0d want %0d (row %0d)", col, e.col, e.row));
				end
				if (value !== e.value) begin
					note_mismatch($sformatf("value at vec %0b row %0d col %0d got %0d want %0d",
						e.is_vec, e.row, e.col, value, e.value));
				end
				if (end_of_run !== e.last) begin
					note_mismatch($sformatf("end_of_run at vec %0b row %0d got %0b want %0b",
						e.is_vec, e.row, end_of_run, e.last));
				end
			end
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			entry_stall <= 1'b1;
		end else if (rx_burst_left > 0) begin
			rx_burst_left--;
			entry_stall <= 1'b1;
		end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
			rx_burst_left = $urandom_range(1, 19) - 1;
			entry_stall <= 1'b1;
		end else begin
			entry_stall <= 1'b0;
		end
	end

	// Field extremes, bit patterns, single-pair sets and a multi-pair set.
	task automatic test_extreme_pairs();
		send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, 1'b1));
		send_pair(make_pair(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
			COORD_HI, COORD_HI, COORD_HI, 1'b1));
		send_pair(make_pair(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
			COORD_LO, COORD_LO, COORD_LO, 1'b1));
		send_pair(make_pair(COORD_HI, COORD_LO, COORD_HI, COORD_LO,
			COORD_LO, COORD_HI, COORD_LO, 1'b1));
		send_pair(make_pair(COORD_LO, COORD_HI, COORD_LO, COORD_HI,
			COORD_HI, COORD_LO, COORD_HI, 1'b1));
		send_pair(make_pair(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
			24'sh555555, 24'shAAAAAA, 24'sh555555, 1'b1));
		// A mostly plausible set: unit w, small offsets and one pair of extremes.
		send_pair(make_pair(24'sh018000, -24'sh020000, 24'sh004000, ONE_Q,
			24'sh018400, -24'sh01F000, 24'sh004800, 1'b0));
		send_pair(make_pair(-24'sh030000, 24'sh008000, 24'sh050000, ONE_Q,
			-24'sh02F800, 24'sh008200, 24'sh04FF00, 1'b0));
		send_pair(make_pair(24'sh000001, -24'sh000001, 24'sh7FFFFF, ONE_Q,
			-24'sh800000, 24'sh000001, -24'sh000001, 1'b0));
		send_pair(make_pair(24'sh0C0000, 24'sh0A0000, -24'sh060000, ONE_Q,
			24'sh0C1000, 24'sh09F000, -24'sh05F000, 1'b1));
		wait_for_entries();
	endtask

	// A long set of extreme pairs drives every sum to a large magnitude, then
	// five pairs with x, w and all target fields of the opposite sign close it.
	task automatic test_extreme_set();
		sender_gaps = 1'b0;
		for (int k = 0; k < BIG_SET_PAIRS; k++) begin
			send_pair(make_pair(COORD_HI, COORD_LO, COORD_HI, COORD_LO,
				COORD_LO, COORD_HI, COORD_LO, 1'b0));
		end
		for (int k = 0; k < 5; k++) begin
			send_pair(make_pair(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
				COORD_HI, COORD_LO, COORD_HI, k == 4));
		end
		sender_gaps = 1'b1;
		wait_for_entries();
	endtask

	// Receiver holds off while several sets arrive back to back, so the
	// output bank fills and the pair channel stalls.
	task automatic test_fill_and_stall();
		sender_gaps = 1'b0;
		rx_hold_left = LONG_HOLD;
		for (int s = 0; s < 4; s++) begin
			for (int k = 0; k < 3; k++) begin
				send_pair(random_pair(k == 2));
			end
		end
		sender_gaps = 1'b1;
		wait_for_entries();
	endtask

	// Random sets of random length with idling on both sides.
	task automatic test_random_sets();
		int sent;
		int len;
		sent = 0;
		while (sent < 250) begin
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			sender_gaps = ($urandom_range(0, 9) < 7);
			receiver_gaps = ($urandom_range(0, 9) < 7);
			for (int k = 0; k < len; k++) begin
				send_pair(random_pair(k == len - 1));
			end
			sent += len;
			if ($urandom_range(0, 7) == 0) begin
				wait_for_entries();
			end
		end
	endtask

	// Closing stretch at full rate with no idling anywhere.
	task automatic test_steady_stream();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		for (int k = 0; k < 40; k++) begin
			send_pair(random_pair(k % 5 == 4));
		end
		pair_valid <= 1'b0;
	endtask

	initial begin
		for (int k = 0; k < N_SUM; k++) begin
			moment_sum[k] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_pairs();
		test_extreme_set();
		test_fill_and_stall();
		test_random_sets();
		test_steady_stream();

		// Let the last sets drain, then allow for stray entries.
		for (int n = 0; n < 20000 && expected_entries.size() != 0; n++) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (expected_entries.size() != 0) begin
			note_mismatch($sformatf("%0d expected entries never arrived",
				expected_entries.size()));
		end

		$display("covered %0d point pairs in %0d sets, %0d system entries checked",
			pairs_sent, sets_closed, entries_seen);
		$display("including a set of %0d extreme pairs and a %0d-cycle receiver hold",
			BIG_SET_PAIRS + 5, LONG_HOLD);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#20000000;
		$display("timeout waiting on the pair or entry channel");
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
design/icpnea_pkg.sv
design/icp_normal_equation_accumulator_unit.sv
tb/sv/tb.sv
